// ----- rtl/core/plsg_pkg.sv -----
// ----------------------------------------------------------------------------
// plsg_pkg : shared types and constants of the periodic latent sequence generator
// Item kinds, generation modes, CSR indexes, parameter defaults, fixed field widths and queue depth.
// ----------------------------------------------------------------------------
package plsg_pkg;

   // Defaults for the top-level parameters
   localparam int PERIOD_MAX_DEFAULT  = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // Fixed field widths
   localparam int FRAC_BITS   = 16;   // Q16.16 fraction
   localparam int STEP_W      = 16;   // step number, saturating
   localparam int MODE_W      = 2;
   localparam int PERIOD_W    = 5;
   localparam int OFFSET_W    = 3;
   localparam int INDEX_W     = 5;    // table index field
   localparam int CSR_INDEX_W = 3;

   // Front-to-back queue depth
   localparam int QUEUE_DEPTH = 2;

   // Input item kinds
   typedef enum logic [1:0] {
      KIND_LOAD_CENTER = 2'd0,
      KIND_LOAD_CHANGE = 2'd1,
      KIND_LOAD_SPREAD = 2'd2,
      KIND_STEP        = 2'd3
   } kind_type;

   // Base value modes (code 3 is undefined: base is zero)
   typedef enum logic [1:0] {
      MODE_CENTER     = 2'd0,
      MODE_ABS_CHANGE = 2'd1,
      MODE_REL_CHANGE = 2'd2
   } mode_type;

   // CSR indexes
   typedef enum logic [2:0] {
      CSR_MODE        = 3'd0,
      CSR_PERIOD      = 3'd1,
      CSR_OFFSET_STEP = 3'd2,
      CSR_MAX_ENABLE  = 3'd3,
      CSR_UPPER_BOUND = 3'd4,
      CSR_MIN_ENABLE  = 3'd5,
      CSR_LOWER_BOUND = 3'd6
   } csr_index_type;

endpackage

// ----- rtl/core/plsg_front.sv -----
// ----------------------------------------------------------------------------
// plsg_front : request front end
// Accepts items, drops out-of-range loads, tracks step and partition counters
// and hands classified entries to the queue.
// ----------------------------------------------------------------------------
module plsg_front #(
   parameter type entry_type  = logic,
   parameter int  PERIOD_MAX  = plsg_pkg::PERIOD_MAX_DEFAULT,
   parameter int  VALUE_WIDTH = plsg_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_kind,
   input  logic [plsg_pkg::INDEX_W-1:0]        req_table_index,
   input  logic signed [VALUE_WIDTH-1:0]       req_table_value,
   input  logic                                req_restart,
   input  logic                                req_has_constraint,
   input  logic signed [VALUE_WIDTH-1:0]       req_constraint_value,
   input  logic [plsg_pkg::PERIOD_W-1:0]       period,
   output logic                                push_valid,
   input  logic                                push_ready,
   output entry_type                           push_data
);
   import plsg_pkg::*;

   localparam int IDX_W = (PERIOD_MAX > 1) ? $clog2(PERIOD_MAX) : 1;
   localparam int CI_W  = $clog2(PERIOD_MAX + 1);

   logic [STEP_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0]  part_ff, part_in;

   logic              accept;
   logic              is_step;
   logic              load_ok;
   kind_type          kind;
   logic [CI_W-1:0]   per;
   logic [STEP_W-1:0] step_t;
   logic [IDX_W-1:0]  part_raw;
   logic [IDX_W-1:0]  part_p;
   logic [CI_W-1:0]   part_inc;
   logic [CI_W-1:0]   chg_idx;

   assign kind      = kind_type'(req_kind);
   assign is_step   = (kind == KIND_STEP);
   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   // Effective period: zero acts as one, clipped to the table depth
   always_comb begin
      if (period == '0) begin
         per = CI_W'(1);
      end else if (32'(period) > 32'(PERIOD_MAX)) begin
         per = CI_W'(PERIOD_MAX);
      end else begin
         per = CI_W'(period);
      end
   end

   // Timestep and partition of this step
   always_comb begin
      step_t   = req_restart ? '0 : step_ff;
      part_raw = req_restart ? '0 : part_ff;
      part_p   = (CI_W'(part_raw) >= per) ? '0 : part_raw;
      part_inc = CI_W'(part_p) + 1'b1;
      part_in  = (part_inc >= per) ? '0 : IDX_W'(part_inc);
      step_in  = (step_t != {STEP_W{1'b1}}) ? step_t + 1'b1 : step_t;
      chg_idx  = (part_p == '0) ? per : CI_W'(part_p);
   end

   // Range check of table loads
   always_comb begin
      unique case (kind)
         KIND_LOAD_CHANGE: load_ok = (32'(req_table_index) <= 32'(PERIOD_MAX));
         KIND_LOAD_CENTER,
         KIND_LOAD_SPREAD: load_ok = (32'(req_table_index) < 32'(PERIOD_MAX));
         default:          load_ok = 1'b1;
      endcase
   end

   // Classified entry
   always_comb begin
      push_valid            = req_valid && load_ok;
      push_data.kind        = kind;
      push_data.index       = is_step ? chg_idx : CI_W'(req_table_index);
      push_data.part        = part_p;
      push_data.first       = (step_t == '0);
      push_data.has_c       = req_has_constraint;
      push_data.value       = is_step ? req_constraint_value : req_table_value;
      push_data.step_number = step_t;
   end

   // Counters advance on each step transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         part_ff <= '0;
      end else if (accept && is_step) begin
         step_ff <= step_in;
         part_ff <= part_in;
      end
   end

endmodule

// ----- rtl/core/plsg_queue.sv -----
// ----------------------------------------------------------------------------
// plsg_queue : front-to-back entry queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module plsg_queue #(
   parameter type entry_type = logic,
   parameter int  DEPTH      = plsg_pkg::QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_data,
   output logic      pop_valid,
   input  logic      pop_ready,
   output entry_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/core/plsg_back.sv -----
// ----------------------------------------------------------------------------
// plsg_back : execution back end
// Applies table loads, forms the base value and carried base, adds the
// spread offset, applies constraint and clamps, and holds the response.
// ----------------------------------------------------------------------------
module plsg_back #(
   parameter type entry_type  = logic,
   parameter int  PERIOD_MAX  = plsg_pkg::PERIOD_MAX_DEFAULT,
   parameter int  VALUE_WIDTH = plsg_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 pop_valid,
   output logic                                 pop_ready,
   input  entry_type                            pop_data,
   input  logic [plsg_pkg::MODE_W-1:0]          mode,
   input  logic signed [plsg_pkg::OFFSET_W-1:0] offset_step,
   input  logic                                 max_enable,
   input  logic signed [VALUE_WIDTH-1:0]        upper_bound,
   input  logic                                 min_enable,
   input  logic signed [VALUE_WIDTH-1:0]        lower_bound,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [VALUE_WIDTH-1:0]        rsp_value,
   output logic [plsg_pkg::STEP_W-1:0]          rsp_step_number
);
   import plsg_pkg::*;

   localparam int W      = VALUE_WIDTH;
   localparam int IDX_W  = (PERIOD_MAX > 1) ? $clog2(PERIOD_MAX) : 1;
   localparam int ABS_W  = W + 1;
   localparam int ONE_W  = W + 2;
   localparam int PROD_W = W + ONE_W;
   localparam int SHR_W  = PROD_W - FRAC_BITS;
   localparam int REL_W  = SHR_W + 1;
   localparam int OFFP_W = W + OFFSET_W;
   localparam int OUT_W  = OFFP_W + 1;

   localparam logic signed [W-1:0]     VMAX = {1'b0, {(W - 1){1'b1}}};
   localparam logic signed [W-1:0]     VMIN = {1'b1, {(W - 1){1'b0}}};
   localparam logic signed [ONE_W-1:0] ONE  = ONE_W'(1 << FRAC_BITS);

   // Tables, undefined until loaded
   logic signed [W-1:0] center_tbl_ff [PERIOD_MAX];
   logic signed [W-1:0] change_tbl_ff [PERIOD_MAX + 1];
   logic signed [W-1:0] spread_tbl_ff [PERIOD_MAX];

   logic signed [W-1:0] cb_ff, cb_in;

   // Stage A: base and spread offset
   logic                     a_valid_ff;
   logic signed [W-1:0]      a_base_ff, a_base_in;
   logic signed [OFFP_W-1:0] a_prod_ff, a_prod_in;
   logic                     a_has_c_ff;
   logic signed [W-1:0]      a_cval_ff;
   logic [STEP_W-1:0]        a_step_ff;

   // Response register
   logic                rsp_valid_ff;
   logic signed [W-1:0] rsp_value_ff, rsp_value_in;
   logic [STEP_W-1:0]   rsp_step_ff;

   logic                     out_adv;
   logic                     pop;
   logic                     step_pop;
   logic                     cb_upd;
   logic signed [W-1:0]      entry_val;
   logic signed [W-1:0]      chg;
   logic signed [W-1:0]      spr;
   logic signed [ABS_W-1:0]  abs_sum;
   logic signed [W-1:0]      abs_sat;
   logic signed [ONE_W-1:0]  cb_plus_one;
   logic signed [PROD_W-1:0] rel_prod;
   logic signed [SHR_W-1:0]  rel_shr;
   logic signed [REL_W-1:0]  rel_sum;
   logic signed [W-1:0]      rel_sat;
   logic signed [OUT_W-1:0]  out_sum;
   logic signed [W-1:0]      out_sat;

   // Handshake: back stages move when the response slot frees
   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign pop_ready = !a_valid_ff || out_adv;
   assign pop       = pop_valid && pop_ready;
   assign step_pop  = pop && (pop_data.kind == KIND_STEP);

   assign entry_val = pop_data.value;
   assign chg       = change_tbl_ff[pop_data.index];
   assign spr       = spread_tbl_ff[pop_data.part];

   // Carried-base arithmetic, one multiply-add per step
   always_comb begin
      abs_sum     = ABS_W'(cb_ff) + ABS_W'(chg);
      cb_plus_one = ONE_W'(cb_ff) + ONE;
      rel_prod    = chg * cb_plus_one;
      rel_shr     = rel_prod[PROD_W-1:FRAC_BITS];
      rel_sum     = REL_W'(cb_ff) + REL_W'(rel_shr);

      if (abs_sum > ABS_W'(VMAX)) begin
         abs_sat = VMAX;
      end else if (abs_sum < ABS_W'(VMIN)) begin
         abs_sat = VMIN;
      end else begin
         abs_sat = abs_sum[W-1:0];
      end

      if (rel_sum > REL_W'(VMAX)) begin
         rel_sat = VMAX;
      end else if (rel_sum < REL_W'(VMIN)) begin
         rel_sat = VMIN;
      end else begin
         rel_sat = rel_sum[W-1:0];
      end
   end

   // Base selection per mode
   always_comb begin
      a_base_in = '0;
      cb_upd    = 1'b0;
      a_prod_in = offset_step * spr;
      unique case (mode)
         MODE_CENTER: begin
            a_base_in = center_tbl_ff[pop_data.part];
         end
         MODE_ABS_CHANGE,
         MODE_REL_CHANGE: begin
            cb_upd = 1'b1;
            priority if (pop_data.first) begin
               a_base_in = center_tbl_ff[0];
            end else if (pop_data.has_c) begin
               a_base_in = entry_val;
            end else if (mode == MODE_ABS_CHANGE) begin
               a_base_in = abs_sat;
            end else begin
               a_base_in = rel_sat;
            end
         end
         default: begin
            a_base_in = '0;
         end
      endcase
      cb_in = (step_pop && cb_upd) ? a_base_in : cb_ff;
   end

   // Table loads
   always_ff @(posedge clock) begin
      if (pop) begin
         unique case (pop_data.kind)
            KIND_LOAD_CENTER: center_tbl_ff[pop_data.index[IDX_W-1:0]] <= entry_val;
            KIND_LOAD_CHANGE: change_tbl_ff[pop_data.index]            <= entry_val;
            KIND_LOAD_SPREAD: spread_tbl_ff[pop_data.index[IDX_W-1:0]] <= entry_val;
            default: ;
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cb_ff        <= '0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cb_ff <= cb_in;
         if (pop_ready) begin
            a_valid_ff <= step_pop;
         end
         if (out_adv) begin
            rsp_valid_ff <= a_valid_ff;
         end
      end
   end

   // Stage A payload
   always_ff @(posedge clock) begin
      if (step_pop) begin
         a_base_ff  <= a_base_in;
         a_prod_ff  <= a_prod_in;
         a_has_c_ff <= pop_data.has_c;
         a_cval_ff  <= entry_val;
         a_step_ff  <= pop_data.step_number;
      end
   end

   // Offset sum, constraint override, then upper and lower clamp
   always_comb begin
      out_sum = OUT_W'(a_base_ff) + OUT_W'(a_prod_ff);
      if (out_sum > OUT_W'(VMAX)) begin
         out_sat = VMAX;
      end else if (out_sum < OUT_W'(VMIN)) begin
         out_sat = VMIN;
      end else begin
         out_sat = out_sum[W-1:0];
      end
      rsp_value_in = a_has_c_ff ? a_cval_ff : out_sat;
      if (max_enable && (rsp_value_in > upper_bound)) begin
         rsp_value_in = upper_bound;
      end
      if (min_enable && (rsp_value_in < lower_bound)) begin
         rsp_value_in = lower_bound;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (out_adv && a_valid_ff) begin
         rsp_value_ff <= rsp_value_in;
         rsp_step_ff  <= a_step_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_step_number = rsp_step_ff;

endmodule

// ----- rtl/core/periodic_latent_sequence_generator.sv -----
// A step's response passes the entry queue, stage A and the response register
// after its request transfer. Throughput: one item per cycle while the queue
// has room; the carried base closes its add or multiply-add loop each step.
// Load items produce no response. Reset is synchronous and active high; it
// clears CSRs, counters, carried base and valid state. The centre, change
// and spread tables hold no reset value and must be loaded before use.
// ----------------------------------------------------------------------------
// periodic_latent_sequence_generator : top level
// CSR bank, front end, entry queue and back end of the sequence generator.
// ----------------------------------------------------------------------------
module periodic_latent_sequence_generator #(
   parameter int PERIOD_MAX  = plsg_pkg::PERIOD_MAX_DEFAULT,
   parameter int VALUE_WIDTH = plsg_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Configuration writes
   input  logic                                csr_write,
   input  logic [plsg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [VALUE_WIDTH-1:0]              csr_wdata,
   // Request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_kind,
   input  logic [plsg_pkg::INDEX_W-1:0]        req_table_index,
   input  logic signed [VALUE_WIDTH-1:0]       req_table_value,
   input  logic                                req_restart,
   input  logic                                req_has_constraint,
   input  logic signed [VALUE_WIDTH-1:0]       req_constraint_value,
   // Response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [VALUE_WIDTH-1:0]       rsp_value,
   output logic [plsg_pkg::STEP_W-1:0]         rsp_step_number
);
   import plsg_pkg::*;

   localparam int IDX_W = (PERIOD_MAX > 1) ? $clog2(PERIOD_MAX) : 1;
   localparam int CI_W  = $clog2(PERIOD_MAX + 1);

   typedef struct packed {
      kind_type                 kind;
      logic [CI_W-1:0]          index;        // table index, or change index on a step
      logic [IDX_W-1:0]         part;         // partition of a step
      logic                     first;        // timestep zero
      logic                     has_c;
      logic [VALUE_WIDTH-1:0]   value;        // table value or constraint value
      logic [STEP_W-1:0]        step_number;
   } queue_entry_type;

   // CSRs
   logic [MODE_W-1:0]             mode_ff;
   logic [PERIOD_W-1:0]           period_ff;
   logic signed [OFFSET_W-1:0]    offset_ff;
   logic                          max_en_ff;
   logic signed [VALUE_WIDTH-1:0] upper_ff;
   logic                          min_en_ff;
   logic signed [VALUE_WIDTH-1:0] lower_ff;

   queue_entry_type push_data;
   queue_entry_type pop_data;
   logic            push_valid;
   logic            push_ready;
   logic            pop_valid;
   logic            pop_ready;

   // CSR write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= '0;
         period_ff <= PERIOD_W'(1);
         offset_ff <= '0;
         max_en_ff <= 1'b0;
         upper_ff  <= '0;
         min_en_ff <= 1'b0;
         lower_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MODE:        mode_ff   <= csr_wdata[MODE_W-1:0];
            CSR_PERIOD:      period_ff <= csr_wdata[PERIOD_W-1:0];
            CSR_OFFSET_STEP: offset_ff <= csr_wdata[OFFSET_W-1:0];
            CSR_MAX_ENABLE:  max_en_ff <= csr_wdata[0];
            CSR_UPPER_BOUND: upper_ff  <= csr_wdata;
            CSR_MIN_ENABLE:  min_en_ff <= csr_wdata[0];
            CSR_LOWER_BOUND: lower_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   plsg_front #(
      .entry_type  (queue_entry_type),
      .PERIOD_MAX  (PERIOD_MAX),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_table_index      (req_table_index),
      .req_table_value      (req_table_value),
      .req_restart          (req_restart),
      .req_has_constraint   (req_has_constraint),
      .req_constraint_value (req_constraint_value),
      .period               (period_ff),
      .push_valid           (push_valid),
      .push_ready           (push_ready),
      .push_data            (push_data)
   );

   plsg_queue #(
      .entry_type (queue_entry_type),
      .DEPTH      (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   plsg_back #(
      .entry_type  (queue_entry_type),
      .PERIOD_MAX  (PERIOD_MAX),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_data        (pop_data),
      .mode            (mode_ff),
      .offset_step     (offset_ff),
      .max_enable      (max_en_ff),
      .upper_bound     (upper_ff),
      .min_enable      (min_en_ff),
      .lower_bound     (lower_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_value       (rsp_value),
      .rsp_step_number (rsp_step_number)
   );

endmodule

// ----- sim/tb_periodic_latent_sequence_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_latent_sequence_generator : self-checking testbench
// Drives table loads and step items over the request channel. A behavioural
// copy of the generator predicts each step's value and step number, and the
// response side compares every transfer against the oldest prediction. The
// run covers directed corner cases, randomised configurations and sequences,
// and back-pressure.
// ----------------------------------------------------------------------------
module tb_periodic_latent_sequence_generator;
   import plsg_pkg::*;

   localparam int           PERIOD_MAX     = PERIOD_MAX_DEFAULT;
   localparam int           STALL_LIMIT    = 2000;   // cycles without any transfer
   localparam logic [1:0]   MODE_UNDEFINED = 2'd3;
   localparam logic [2:0]   CSR_UNMAPPED   = 3'd7;
   localparam longint       Q_MAX          = 64'sh0000_0000_7FFF_FFFF;
   localparam longint       Q_MIN          = -Q_MAX - 1;

   typedef struct {
      kind_type    kind;
      logic [4:0]  tindex;
      logic [31:0] tvalue;
      logic        restart;
      logic        has_con;
      logic [31:0] con_value;
   } stream_item_type;

   typedef struct {
      logic [31:0] value;
      logic [15:0] step;
   } seq_result_type;

   // DUT connections, all driven from time zero
   logic        clock                = 1'b0;
   logic        reset                = 1'b1;
   logic        csr_write            = 1'b0;
   logic [2:0]  csr_index            = '0;
   logic [31:0] csr_wdata            = '0;
   logic        req_valid            = 1'b0;
   logic        req_ready;
   logic [1:0]  req_kind             = '0;
   logic [4:0]  req_table_index      = '0;
   logic [31:0] req_table_value      = '0;
   logic        req_restart          = 1'b0;
   logic        req_has_constraint   = 1'b0;
   logic [31:0] req_constraint_value = '0;
   logic        rsp_valid;
   logic        rsp_ready            = 1'b0;
   logic [31:0] rsp_value;
   logic [15:0] rsp_step_number;

   // Test control
   bit             idle_enable     = 1'b1;
   int unsigned    rsp_hold_cycles = 0;
   int unsigned    error_count     = 0;
   seq_result_type expected_values[$];

   // Predicted generator state and configuration
   logic [1:0]        cfg_mode   = MODE_CENTER;
   logic [4:0]        cfg_period = 5'd1;
   logic signed [2:0] cfg_offset = '0;
   logic              cfg_max_en = 1'b0;
   logic              cfg_min_en = 1'b0;
   longint            cfg_upper  = 0;
   longint            cfg_lower  = 0;
   longint            carried    = 0;
   int unsigned       step_cnt   = 0;
   int unsigned       part_cnt   = 0;
   longint            center_tab [PERIOD_MAX];
   longint            change_tab [PERIOD_MAX+1];
   longint            spread_tab [PERIOD_MAX];
   bit                center_set [PERIOD_MAX];
   bit                change_set [PERIOD_MAX+1];
   bit                spread_set [PERIOD_MAX];

   periodic_latent_sequence_generator dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_table_index      (req_table_index),
      .req_table_value      (req_table_value),
      .req_restart          (req_restart),
      .req_has_constraint   (req_has_constraint),
      .req_constraint_value (req_constraint_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_value            (rsp_value),
      .rsp_step_number      (rsp_step_number)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Behavioural prediction
   // ------------------------------------------------------------------------
   function automatic longint saturate_q16(input longint x);
      if (x > Q_MAX) return Q_MAX;
      if (x < Q_MIN) return Q_MIN;
      return x;
   endfunction

   function automatic int unsigned active_period();
      if (cfg_period == 0) return 1;
      if (cfg_period > PERIOD_MAX) return PERIOD_MAX;
      return cfg_period;
   endfunction

   // Updates tables or sequence state for one accepted item; steps queue a result
   task automatic predict_sequence_value(input stream_item_type it);
      int unsigned    per, t, p, ci;
      longint         base, val, chg;
      seq_result_type res;
      case (it.kind)
         KIND_LOAD_CENTER: if (it.tindex < PERIOD_MAX) begin
            center_tab[it.tindex] = $signed(it.tvalue);
            center_set[it.tindex] = 1'b1;
         end
         KIND_LOAD_CHANGE: if (it.tindex <= PERIOD_MAX) begin
            change_tab[it.tindex] = $signed(it.tvalue);
            change_set[it.tindex] = 1'b1;
         end
         KIND_LOAD_SPREAD: if (it.tindex < PERIOD_MAX) begin
            spread_tab[it.tindex] = $signed(it.tvalue);
            spread_set[it.tindex] = 1'b1;
         end
         default: begin
            per = active_period();
            if (it.restart) begin
               step_cnt = 0;
               part_cnt = 0;
            end
            t = step_cnt;
            p = part_cnt;
            if (p >= per) p = 0;
            // base value per mode; change modes carry it between steps
            case (cfg_mode)
               MODE_CENTER: base = center_tab[p];
               MODE_ABS_CHANGE, MODE_REL_CHANGE: begin
                  if (t == 0) begin
                     base = center_tab[0];
                  end else begin
                     ci  = (p == 0) ? per : p;
                     chg = change_tab[ci];
                     if (cfg_mode == MODE_ABS_CHANGE)
                        base = saturate_q16(carried + chg);
                     else
                        base = saturate_q16(carried + ((chg * (carried + 65536)) >>> 16));
                     if (it.has_con) base = $signed(it.con_value);
                  end
                  carried = base;
               end
               default: base = 0;
            endcase
            // spread offset or constraint, then the clamps
            if (it.has_con)
               val = $signed(it.con_value);
            else
               val = saturate_q16(base + longint'(cfg_offset) * spread_tab[p]);
            if (cfg_max_en && val > cfg_upper) val = cfg_upper;
            if (cfg_min_en && val < cfg_lower) val = cfg_lower;
            res.value = val[31:0];
            res.step  = t[15:0];
            expected_values.insert(expected_values.size(), res);
            if (step_cnt < 65535) step_cnt++;
            part_cnt = (p + 1 >= per) ? 0 : p + 1;
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   task automatic send_item(input stream_item_type it);
      if (idle_enable && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_kind             <= it.kind;
      req_table_index      <= it.tindex;
      req_table_value      <= it.tvalue;
      req_restart          <= it.restart;
      req_has_constraint   <= it.has_con;
      req_constraint_value <= it.con_value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_sequence_value(it);
   endtask

   task automatic send_load(input kind_type k, input logic [4:0] idx, input logic [31:0] v);
      stream_item_type it;
      it.kind      = k;
      it.tindex    = idx;
      it.tvalue    = v;
      it.restart   = 1'($urandom);
      it.has_con   = 1'($urandom);
      it.con_value = $urandom;
      send_item(it);
   endtask

   function automatic logic [31:0] pick_q16();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2, 3:    return $urandom;
         default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;   // +-4.0
      endcase
   endfunction

   // Never let a step read a table entry that has not been written
   task automatic load_missing_entries(input logic restart);
      int unsigned per, p, ci;
      per = active_period();
      p   = restart ? 0 : part_cnt;
      if (p >= per) p = 0;
      ci  = (p == 0) ? per : p;
      if (!center_set[0])  send_load(KIND_LOAD_CENTER, 5'd0, pick_q16());
      if (!center_set[p])  send_load(KIND_LOAD_CENTER, 5'(p), pick_q16());
      if (!spread_set[p])  send_load(KIND_LOAD_SPREAD, 5'(p), pick_q16());
      if (!change_set[ci]) send_load(KIND_LOAD_CHANGE, 5'(ci), pick_q16());
   endtask

   task automatic send_step(input logic restart, input logic has_con,
                            input logic [31:0] con_value);
      stream_item_type it;
      load_missing_entries(restart);
      it.kind      = KIND_STEP;
      it.tindex    = 5'($urandom);
      it.tvalue    = $urandom;
      it.restart   = restart;
      it.has_con   = has_con;
      it.con_value = con_value;
      send_item(it);
   endtask

   // Drop valid, let every expected result arrive, then let the pipe settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_values.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Configuration
   // ------------------------------------------------------------------------
   task automatic write_csr(input logic [2:0] idx, input logic [31:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_MODE:        cfg_mode   = data[1:0];
         CSR_PERIOD:      cfg_period = data[4:0];
         CSR_OFFSET_STEP: cfg_offset = data[2:0];
         CSR_MAX_ENABLE:  cfg_max_en = data[0];
         CSR_UPPER_BOUND: cfg_upper  = $signed(data);
         CSR_MIN_ENABLE:  cfg_min_en = data[0];
         CSR_LOWER_BOUND: cfg_lower  = $signed(data);
         default: ;
      endcase
   endtask

   // Writes every register; unused upper data bits carry random noise
   task automatic configure(input logic [1:0] m, input logic [4:0] per,
                            input logic [2:0] ofs, input logic max_en,
                            input logic [31:0] upper, input logic min_en,
                            input logic [31:0] lower);
      logic [31:0] fill;
      fill = $urandom;
      write_csr(CSR_MODE,        {fill[31:2], m});
      write_csr(CSR_PERIOD,      {fill[31:5], per});
      write_csr(CSR_OFFSET_STEP, {fill[31:3], ofs});
      write_csr(CSR_MAX_ENABLE,  {fill[31:1], max_en});
      write_csr(CSR_UPPER_BOUND, upper);
      write_csr(CSR_MIN_ENABLE,  {fill[30:0], min_en});
      write_csr(CSR_LOWER_BOUND, lower);
      if ($urandom_range(0, 3) == 0) write_csr(CSR_UNMAPPED, $urandom);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure_random();
      logic [1:0] m;
      logic [4:0] per;
      case ($urandom_range(0, 9))
         0:          m = MODE_UNDEFINED;
         1, 2, 3:    m = MODE_CENTER;
         4, 5, 6:    m = MODE_ABS_CHANGE;
         default:    m = MODE_REL_CHANGE;
      endcase
      case ($urandom_range(0, 9))
         0:       per = 5'd0;
         1:       per = 5'd1;
         2:       per = 5'd16;
         3:       per = 5'($urandom_range(17, 31));
         default: per = 5'($urandom_range(2, 15));
      endcase
      configure(m, per, 3'($urandom), 1'($urandom), pick_q16(), 1'($urandom), pick_q16());
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Reset configuration, ignored load indexes, first step without restart
   task automatic test_loads_and_first_step();
      send_load(KIND_LOAD_CENTER, 5'd0,  32'h7FFF_FFFF);
      send_load(KIND_LOAD_SPREAD, 5'd0,  32'h8000_0000);
      send_load(KIND_LOAD_CENTER, 5'd16, 32'h1234_5678);   // out of range
      send_load(KIND_LOAD_SPREAD, 5'd31, 32'h1234_5678);   // out of range
      send_load(KIND_LOAD_CHANGE, 5'd16, 32'h0001_0000);   // top change entry
      send_load(KIND_LOAD_CHANGE, 5'd17, 32'h1234_5678);   // out of range
      send_step(1'b0, 1'b0, '0);
      send_step(1'b0, 1'b1, 32'h8000_0000);
      send_step(1'b1, 1'b0, '0);
   endtask

   // Saturating sums, constraint overriding the carried base, undefined mode, clamps
   task automatic test_saturating_arithmetic();
      wait_idle();
      configure(MODE_ABS_CHANGE, 5'd2, 3'b100, 1'b0, '0, 1'b0, '0);
      send_load(KIND_LOAD_CENTER, 5'd0, 32'h7FFF_FFFF);
      send_load(KIND_LOAD_SPREAD, 5'd0, 32'h7FFF_FFFF);
      send_load(KIND_LOAD_SPREAD, 5'd1, 32'h8000_0000);
      send_load(KIND_LOAD_CHANGE, 5'd1, 32'h7FFF_FFFF);
      send_load(KIND_LOAD_CHANGE, 5'd2, 32'h8000_0000);
      send_step(1'b1, 1'b0, '0);
      send_step(1'b0, 1'b0, '0);
      send_step(1'b0, 1'b0, '0);
      send_step(1'b0, 1'b1, 32'h0001_0000);
      wait_idle();
      configure(MODE_UNDEFINED, 5'd17, 3'd3, 1'b1, 32'h0002_0000, 1'b1, 32'h0003_0000);
      send_step(1'b1, 1'b0, '0);
      send_step(1'b0, 1'b0, '0);
   endtask

   // Relative change with a negative product rounded towards minus infinity
   task automatic test_relative_rounding();
      wait_idle();
      configure(MODE_REL_CHANGE, 5'd0, 3'd0, 1'b0, '0, 1'b0, '0);
      send_load(KIND_LOAD_CENTER, 5'd0, 32'hFFFF_FFFD);
      send_load(KIND_LOAD_CHANGE, 5'd1, 32'hFFFF_8000);
      send_step(1'b1, 1'b1, 32'h0005_0000);   // constraint at step zero keeps centre
      send_step(1'b0, 1'b0, '0);
      send_step(1'b0, 1'b0, '0);
      send_step(1'b0, 1'b1, 32'hFFFE_0000);
   endtask

   // Random configurations, each followed by a mostly well-formed sequence
   task automatic test_random_sequences(input int unsigned target);
      int unsigned sent, len, r;
      kind_type    k;
      logic [4:0]  idx;
      sent = 0;
      while (sent < target) begin
         wait_idle();
         configure_random();
         len = $urandom_range(4, 48);
         for (int n = 0; n < len; n++) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
               k   = kind_type'($urandom_range(0, 2));
               idx = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(16, 31))
                                                 : 5'($urandom_range(0, 15));
               send_load(k, idx, pick_q16());
               if (idx < PERIOD_MAX || (k == KIND_LOAD_CHANGE && idx == PERIOD_MAX))
                  sent++;
            end else begin
               // sequence usually opens with a restart; a stray mid-sequence restart is noise
               send_step((n == 0) ? ($urandom_range(0, 4) != 0) : (r < 13),
                         $urandom_range(0, 9) == 0, pick_q16());
               sent++;
            end
         end
      end
   endtask

   // Long receiver hold-off that fills the block, then a full drain mid-sequence
   task automatic test_backpressure();
      wait_idle();
      configure(MODE_ABS_CHANGE, 5'd3, 3'd1, 1'b0, '0, 1'b0, '0);
      rsp_hold_cycles = 120;
      send_step(1'b1, 1'b0, '0);
      repeat (30) send_step(1'b0, $urandom_range(0, 7) == 0, pick_q16());
      wait_idle();
      repeat (20) send_step(1'b0, $urandom_range(0, 7) == 0, pick_q16());
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------
   initial begin : response_sink
      forever begin
         if (rsp_hold_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      error_count++;
      if (error_count <= 10)
         $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
   endtask

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin : result_check
      seq_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_values.size() == 0) begin
            report_mismatch("unexpected transfer value", '0, rsp_value);
         end else begin
            want = expected_values.pop_front();
            if (rsp_value !== want.value)
               report_mismatch("value", want.value, rsp_value);
            if (rsp_step_number !== want.step)
               report_mismatch("step_number", want.step, rsp_step_number);
         end
      end
   end

   // Watchdog: ends the run after too long without any transfer
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : run
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_loads_and_first_step();
      test_saturating_arithmetic();
      test_relative_rounding();
      test_random_sequences(700);
      test_backpressure();
      // final stretch runs without idling on either side
      idle_enable = 1'b0;
      test_random_sequences(300);
      wait_idle();
      repeat (16) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/plsg_pkg.sv
rtl/core/plsg_front.sv
rtl/core/plsg_queue.sv
rtl/core/plsg_back.sv
rtl/core/periodic_latent_sequence_generator.sv
sim/tb_periodic_latent_sequence_generator.sv
